[sv/linear_probe_hash_table_assert.svh]
// Assertion macros for the hash table block.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lph assertion failed");
`define LPH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lph assertion failed");
`else
`define LPH_ASSERT_IMP(lbl, ante, cons)
`define LPH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/lph_pkg.sv]
// Types, constants and key helpers shared by the hash table modules.
package lph_pkg;

  localparam logic [63:0] K0 = 64'ha0761d6478bd642f;
  localparam logic [63:0] K1 = 64'he7037ed1a0b428db;
  localparam logic [63:0] K2 = 64'h8ebc6af09c88c6e3;
  localparam logic [63:0] K3 = 64'h589965cc75374cc3;
  localparam logic [63:0] K4 = 64'h1d8e4e27c47d124f;

  typedef enum logic [1:0] {CMD_GET, CMD_SET, CMD_DEL, CMD_CLR} cmd_t;
  typedef enum logic [1:0] {RS_OK, RS_MISS, RS_FULL, RS_ZLEN} res_t;
  typedef enum logic [1:0] {ST_EMPTY, ST_TOMB, ST_LIVE, ST_RSVD} slot_st_t;

  typedef enum logic [2:0] {
    T_CLEAR, T_IDLE, T_HASH, T_RD, T_CHK, T_FIN
  } tbl_state_t;

  typedef enum logic {H_IDLE, H_RUN} hsh_state_t;

  // multiply steps of the short-key mix
  typedef enum logic [2:0] {
    HOP_A, HOP_B, HOP_MIX, HOP_S0, HOP_S1, HOP_S2
  } hop_t;

  typedef struct packed {
    slot_st_t    st;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] val;
  } entry_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
  } hab_t;

  function automatic logic [63:0] mul_const(input hop_t op);
    logic [63:0] k;
    case (op)
      HOP_A:   k = K0;
      HOP_B:   k = K1;
      HOP_MIX: k = K0;
      HOP_S0:  k = K0;
      HOP_S1:  k = K1;
      HOP_S2:  k = K4;
      default: k = K0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] word4_at(input logic [63:0] k, input logic [2:0] off);
    logic [63:0] s;
    s = k >> {off, 3'b000};
    return s[31:0];
  endfunction

  function automatic logic [7:0] byte_at(input logic [63:0] k, input logic [2:0] off);
    logic [63:0] s;
    s = k >> {off, 3'b000};
    return s[7:0];
  endfunction

  // key already masked, len 1..8
  function automatic hab_t key_ab(input logic [63:0] k, input logic [3:0] len);
    hab_t r;
    logic [2:0] off;
    logic [2:0] lm4;
    logic [2:0] lm1;
    off = (len >= 4'd8) ? 3'd4 : 3'd0;
    lm4 = 3'(len - 4'd4);
    lm1 = 3'(len - 4'd1);
    if (len >= 4'd4) begin
      r.a = {word4_at(k, 3'd0), word4_at(k, off)};
      r.b = {word4_at(k, lm4), word4_at(k, 3'(lm4 - off))};
    end else begin
      r.a = {40'd0, byte_at(k, 3'd0), byte_at(k, len[3:1]), byte_at(k, lm1)};
      r.b = 64'd0;
    end
    return r;
  endfunction

endpackage

[sv/lph_hash.sv]
// Key hash: one 32x32 multiplier reused for six 64-bit multiplies.
module lph_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] hash
);

  lph_pkg::hsh_state_t state_r, state_nxt;
  lph_pkg::hop_t       op_r, op_nxt;
  logic [1:0]          ph_r, ph_nxt;
  logic [63:0]         opnd_r, opnd_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic [63:0]         ra_r, ra_nxt;
  logic [63:0]         b_r, b_nxt;
  logic [63:0]         hash_r, hash_nxt;
  logic                done_r, done_nxt;
  logic [63:0]         k;
  logic [31:0]         mx, my;
  logic [63:0]         prod;
  logic [63:0]         m;

  // low 64 bits of opnd*k from three partial products
  always_comb begin
    k    = lph_pkg::mul_const(op_r);
    mx   = (ph_r == 2'd2) ? opnd_r[63:32] : opnd_r[31:0];
    my   = (ph_r == 2'd1) ? k[63:32] : k[31:0];
    prod = mx * my;
    m    = (ph_r == 2'd0) ? prod : acc_r + {prod[31:0], 32'd0};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lph_pkg::H_IDLE: if (start) state_nxt = lph_pkg::H_RUN;
      lph_pkg::H_RUN:  if (ph_r == 2'd2 && op_r == lph_pkg::HOP_S2) state_nxt = lph_pkg::H_IDLE;
      default:         state_nxt = lph_pkg::H_IDLE;
    endcase
  end

  always_comb begin
    op_nxt   = op_r;
    ph_nxt   = ph_r;
    opnd_nxt = opnd_r;
    acc_nxt  = acc_r;
    ra_nxt   = ra_r;
    b_nxt    = b_r;
    hash_nxt = hash_r;
    done_nxt = 1'b0;
    case (state_r)
      lph_pkg::H_IDLE: begin
        op_nxt   = lph_pkg::HOP_A;
        ph_nxt   = 2'd0;
        opnd_nxt = a ^ lph_pkg::K2;
        b_nxt    = b ^ lph_pkg::K3;
      end
      lph_pkg::H_RUN: begin
        acc_nxt = m;
        if (ph_r != 2'd2) begin
          ph_nxt = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          op_nxt = lph_pkg::hop_t'(op_r + 3'd1);
          case (op_r)
            lph_pkg::HOP_A: begin
              ra_nxt   = m;
              opnd_nxt = b_r;
            end
            lph_pkg::HOP_B:   opnd_nxt = {ra_r[31:0], ra_r[63:32]} ^ m;
            lph_pkg::HOP_MIX: opnd_nxt = m;
            lph_pkg::HOP_S2: begin
              hash_nxt = m ^ {32'd0, m[63:32]};
              done_nxt = 1'b1;
            end
            default:          opnd_nxt = m ^ {32'd0, m[63:32]};
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lph_pkg::H_IDLE;
      done_r  <= 1'b0;
      op_r    <= lph_pkg::HOP_A;
      ph_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      op_r    <= op_nxt;
      ph_r    <= ph_nxt;
    end
    opnd_r <= opnd_nxt;
    acc_r  <= acc_nxt;
    ra_r   <= ra_nxt;
    b_r    <= b_nxt;
    hash_r <= hash_nxt;
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

[sv/linear_probe_hash_table.sv]
// Key-value table with open addressing and linear probing.
// Input channel in_*: one command word per handshake. in_tuser holds the
// command (get, set, delete, clear); in_tdata holds key, key length, value.
// Result channel out_*: one word per command with status in out_tuser and
// value found plus live entry count in out_tdata.
// cfg_we/cfg_wdata set log2 of the active slot count; write only when idle.
// A get/set/delete first hashes the key on the one 32x32 multiplier
// (six 64-bit multiplies, three partial products each), then probes
// slot by slot through the registered slot memory (states T_RD, then
// T_CHK per slot), then updates and presents the result in T_FIN.
// A zero key length skips hashing and probing. Clear walks all MAX_SLOTS
// slots one per cycle. One command is in work at a time.
// After reset the same clearing pass runs with in_tready low.
// If the receiver stalls, the result holds in the output register; the
// next command may be accepted meanwhile but finishes only once it drains.
module linear_probe_hash_table #(
  parameter int MAX_SLOTS     = 1024,
  parameter int DEFAULT_SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // cmd
  input  logic [135:0] in_tdata,   // key[63:0], key_length[67:64], value[131:68]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [79:0]  out_tdata,  // value_out[63:0], entry_count[74:64]
  input  logic         cfg_we,
  input  logic [3:0]   cfg_wdata
);

`include "linear_probe_hash_table_assert.svh"

  localparam int IW     = $clog2(MAX_SLOTS);
  localparam int MAX_LG = $clog2(MAX_SLOTS + 1) - 1;
  localparam int DEF_LG = $clog2(DEFAULT_SLOTS + 1) - 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_SLOTS - 1);

  lph_pkg::tbl_state_t state_r, state_nxt;
  logic [3:0]          cfg_r;
  lph_pkg::cmd_t       cmd_r, cmd_nxt;
  logic [63:0]         key_r, key_nxt;
  logic [3:0]          len_r, len_nxt;
  logic [63:0]         val_r, val_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW:0]         n_r, n_nxt;
  logic                tomb_v_r, tomb_v_nxt;
  logic [IW-1:0]       tomb_r, tomb_nxt;
  logic                found_r, found_nxt;
  logic                empty_r, empty_nxt;
  logic [IW-1:0]       where_r, where_nxt;
  logic [10:0]         live_r, live_nxt;
  logic [IW-1:0]       clr_idx_r, clr_idx_nxt;
  logic                clr_resp_r, clr_resp_nxt;
  logic                zl_r, zl_nxt;
  logic                ov_r, ov_nxt;
  lph_pkg::res_t       ostat_r, ostat_nxt;
  logic [63:0]         oval_r, oval_nxt;
  logic [10:0]         ocnt_r, ocnt_nxt;

  lph_pkg::entry_t mem [MAX_SLOTS];
  lph_pkg::entry_t rd_r;
  lph_pkg::entry_t wdata;
  logic            we;
  logic [IW-1:0]   waddr;

  logic [3:0]      lg_eff;
  logic [IW:0]     size;
  logic [IW-1:0]   mask;
  logic            in_acc;
  logic [3:0]      in_len;
  logic [63:0]     in_key;
  lph_pkg::hab_t   hab;
  logic            hash_start;
  logic            hash_done;
  logic [63:0]     hash;
  logic            out_free;
  logic            hit;
  logic            wrap;

  always_comb begin
    if (cfg_r == 4'd0) lg_eff = 4'd1;
    else if (32'(cfg_r) > MAX_LG) lg_eff = 4'(MAX_LG);
    else lg_eff = cfg_r;
    size = (IW + 1)'(1) << lg_eff;
    mask = IW'(size - 1'b1);
  end

  assign in_tready = (state_r == lph_pkg::T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !ov_r || out_tready;

  // clamp length and drop bytes above it
  always_comb begin
    in_len = (in_tdata[67:64] > 4'd8) ? 4'd8 : in_tdata[67:64];
    for (int i = 0; i < 8; i++) begin
      in_key[i*8 +: 8] = (4'(i) < in_len) ? in_tdata[i*8 +: 8] : 8'd0;
    end
    hab = lph_pkg::key_ab(in_key, in_len);
  end

  assign hash_start = in_acc && (lph_pkg::cmd_t'(in_tuser) != lph_pkg::CMD_CLR)
                      && (in_len != 4'd0);

  lph_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .a     (hab.a),
    .b     (hab.b),
    .done  (hash_done),
    .hash  (hash)
  );

  assign hit  = (rd_r.st == lph_pkg::ST_EMPTY) ||
                (rd_r.st == lph_pkg::ST_LIVE && rd_r.len == len_r && rd_r.key == key_r);
  assign wrap = ((n_r + 1'b1) == size);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lph_pkg::T_CLEAR: begin
        if (clr_idx_r == LAST_SLOT) state_nxt = clr_resp_r ? lph_pkg::T_FIN : lph_pkg::T_IDLE;
      end
      lph_pkg::T_IDLE: begin
        if (in_acc) begin
          if (lph_pkg::cmd_t'(in_tuser) == lph_pkg::CMD_CLR) state_nxt = lph_pkg::T_CLEAR;
          else if (in_len == 4'd0) state_nxt = lph_pkg::T_FIN;
          else state_nxt = lph_pkg::T_HASH;
        end
      end
      lph_pkg::T_HASH: if (hash_done) state_nxt = lph_pkg::T_RD;
      lph_pkg::T_RD:   state_nxt = lph_pkg::T_CHK;
      lph_pkg::T_CHK:  state_nxt = (hit || wrap) ? lph_pkg::T_FIN : lph_pkg::T_RD;
      lph_pkg::T_FIN:  if (out_free) state_nxt = lph_pkg::T_IDLE;
      default:         state_nxt = lph_pkg::T_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    len_nxt      = len_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    n_nxt        = n_r;
    tomb_v_nxt   = tomb_v_r;
    tomb_nxt     = tomb_r;
    found_nxt    = found_r;
    empty_nxt    = empty_r;
    where_nxt    = where_r;
    live_nxt     = live_r;
    clr_idx_nxt  = clr_idx_r;
    clr_resp_nxt = clr_resp_r;
    zl_nxt       = zl_r;
    ov_nxt       = ov_r && !out_tready;
    ostat_nxt    = ostat_r;
    oval_nxt     = oval_r;
    ocnt_nxt     = ocnt_r;
    we           = 1'b0;
    waddr        = where_r;
    wdata        = '{st: lph_pkg::ST_LIVE, key: key_r, len: len_r, val: val_r};
    case (state_r)
      lph_pkg::T_CLEAR: begin
        we          = 1'b1;
        waddr       = clr_idx_r;
        wdata.st    = lph_pkg::ST_EMPTY;
        clr_idx_nxt = clr_idx_r + 1'b1;
        live_nxt    = 11'd0;
      end
      lph_pkg::T_IDLE: begin
        cmd_nxt      = lph_pkg::cmd_t'(in_tuser);
        key_nxt      = in_key;
        len_nxt      = in_len;
        val_nxt      = in_tdata[131:68];
        clr_idx_nxt  = '0;
        clr_resp_nxt = 1'b1;
        zl_nxt       = (in_len == 4'd0);
        tomb_v_nxt   = 1'b0;
        found_nxt    = 1'b0;
        empty_nxt    = 1'b0;
      end
      lph_pkg::T_HASH: begin
        idx_nxt = hash[IW-1:0] & mask;
        n_nxt   = '0;
      end
      lph_pkg::T_CHK: begin
        where_nxt = idx_r;
        if (rd_r.st == lph_pkg::ST_EMPTY) empty_nxt = 1'b1;
        else if (hit) found_nxt = 1'b1;
        if (rd_r.st == lph_pkg::ST_TOMB && !tomb_v_r) begin
          tomb_v_nxt = 1'b1;
          tomb_nxt   = idx_r;
        end
        idx_nxt = (idx_r + 1'b1) & mask;
        n_nxt   = n_r + 1'b1;
      end
      lph_pkg::T_FIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oval_nxt  = 64'd0;
          ostat_nxt = lph_pkg::RS_OK;
          if (cmd_r == lph_pkg::CMD_CLR) begin
            live_nxt = 11'd0;
          end else if (zl_r) begin
            ostat_nxt = lph_pkg::RS_ZLEN;
          end else begin
            case (cmd_r)
              lph_pkg::CMD_GET: begin
                if (found_r) oval_nxt = rd_r.val;
                else ostat_nxt = lph_pkg::RS_MISS;
              end
              lph_pkg::CMD_DEL: begin
                if (found_r) begin
                  we       = 1'b1;
                  wdata.st = lph_pkg::ST_TOMB;
                  live_nxt = live_r - 1'b1;
                end else begin
                  ostat_nxt = lph_pkg::RS_MISS;
                end
              end
              lph_pkg::CMD_SET: begin
                if (found_r) begin
                  we = 1'b1;
                end else if (tomb_v_r || empty_r) begin
                  we       = 1'b1;
                  waddr    = tomb_v_r ? tomb_r : where_r;
                  live_nxt = live_r + 1'b1;
                end else begin
                  ostat_nxt = lph_pkg::RS_FULL;
                end
              end
              default: ;
            endcase
          end
          ocnt_nxt = live_nxt;
        end
      end
      default: ;
    endcase
  end

  // read word holds from the probe read until the next one
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (state_r == lph_pkg::T_RD) rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lph_pkg::T_CLEAR;
      cfg_r      <= 4'(DEF_LG);
      live_r     <= 11'd0;
      clr_idx_r  <= '0;
      clr_resp_r <= 1'b0;
      ov_r       <= 1'b0;
      zl_r       <= 1'b0;
      cmd_r      <= lph_pkg::CMD_GET;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) cfg_r <= cfg_wdata;
      live_r     <= live_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_resp_r <= clr_resp_nxt;
      ov_r       <= ov_nxt;
      zl_r       <= zl_nxt;
      cmd_r      <= cmd_nxt;
    end
    key_r    <= key_nxt;
    len_r    <= len_nxt;
    val_r    <= val_nxt;
    idx_r    <= idx_nxt;
    n_r      <= n_nxt;
    tomb_v_r <= tomb_v_nxt;
    tomb_r   <= tomb_nxt;
    found_r  <= found_nxt;
    empty_r  <= empty_nxt;
    where_r  <= where_nxt;
    ostat_r  <= ostat_nxt;
    oval_r   <= oval_nxt;
    ocnt_r   <= ocnt_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ostat_r;
  assign out_tdata  = {5'd0, ocnt_r, oval_r};

  `LPH_ASSERT_IMP(a_no_accept_in_clear, state_r == lph_pkg::T_CLEAR, !in_tready)
  `LPH_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != lph_pkg::T_IDLE)
  `LPH_ASSERT_IMP(a_hash_done_in_hash, hash_done, state_r == lph_pkg::T_HASH)

endmodule
